@@ sv/stepper_ramp_step_generator_core_defines.svh @@
// Assertion macros shared by the stepper ramp step generator.
`ifndef STEPPER_RAMP_STEP_GENERATOR_CORE_DEFINES_SVH
`define STEPPER_RAMP_STEP_GENERATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define SRSG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define SRSG_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define SRSG_ASSERT(name, prop, msg)

`define SRSG_ASSERT_NEVER(name, cond, msg)

`endif

`endif

@@ sv/srsg_pkg.sv @@
package srsg_pkg;

  localparam int unsigned StepCountBitsDef = 20;
  localparam int unsigned PeriodBitsDef    = 16;
  localparam int unsigned PositionBitsDef  = 24;

  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned RampBits    = 16;

  localparam logic [31:0]         StartPeriodReset = 32'd2000;
  localparam logic [RampBits-1:0] RampStepReset    = 16'd10;
  localparam logic [31:0]         HomePosition     = 32'd100000;

  typedef enum logic [0:0] {
    CfgStartPeriod = 1'b0,
    CfgRampStep    = 1'b1
  } cfg_reg_e;

endpackage

@@ sv/srsg_period_pick.sv @@
module srsg_period_pick import srsg_pkg::*; #(
  parameter int unsigned STEP_COUNT_BITS = StepCountBitsDef,
  parameter int unsigned PERIOD_BITS     = PeriodBitsDef
) (
  input  logic [STEP_COUNT_BITS-1:0] total_steps_i,
  input  logic [STEP_COUNT_BITS-1:0] remaining_steps_i,
  input  logic [PERIOD_BITS-1:0]     present_period_i,
  input  logic [PERIOD_BITS-1:0]     cruise_period_i,
  input  logic [PERIOD_BITS-1:0]     start_period_i,
  input  logic [RampBits-1:0]        ramp_step_i,
  output logic [PERIOD_BITS-1:0]     upcoming_period_o
);

  localparam int unsigned SumBits  = ((PERIOD_BITS > RampBits) ? PERIOD_BITS : RampBits) + 1;
  localparam int unsigned ProdBits = STEP_COUNT_BITS + RampBits;
  localparam int unsigned CmpBits  = (ProdBits > PERIOD_BITS) ? ProdBits : PERIOD_BITS;

  logic [STEP_COUNT_BITS-1:0] done_steps;
  logic                       accelerate;
  logic [SumBits-1:0]         cur_ext;
  logic [SumBits-1:0]         cruise_plus_ramp;
  logic [SumBits-1:0]         cur_minus_ramp;
  logic [SumBits-1:0]         cur_plus_ramp;
  logic [SumBits-1:0]         start_ext;
  logic [PERIOD_BITS-1:0]     slack;
  logic [CmpBits-1:0]         brake_span;
  logic                       brake;

  assign done_steps       = total_steps_i - remaining_steps_i;
  assign accelerate       = remaining_steps_i > done_steps;
  assign cur_ext          = SumBits'(present_period_i);
  assign start_ext        = SumBits'(start_period_i);
  assign cruise_plus_ramp = SumBits'(cruise_period_i) + SumBits'(ramp_step_i);
  assign cur_minus_ramp   = cur_ext - SumBits'(ramp_step_i);
  assign cur_plus_ramp    = cur_ext + SumBits'(ramp_step_i);
  assign slack            = start_period_i - present_period_i;
  assign brake_span       = CmpBits'(remaining_steps_i) * CmpBits'(ramp_step_i);
  assign brake            = (present_period_i <= start_period_i) &&
                            (brake_span <= CmpBits'(slack));

  always_comb begin
    upcoming_period_o = cruise_period_i;
    if (accelerate) begin
      if ((present_period_i > cruise_period_i) && (cur_ext >= cruise_plus_ramp)) begin
        upcoming_period_o = PERIOD_BITS'(cur_minus_ramp);
      end
    end else if (brake) begin
      if ((present_period_i < start_period_i) && (cur_plus_ramp <= start_ext)) begin
        upcoming_period_o = PERIOD_BITS'(cur_plus_ramp);
      end else begin
        upcoming_period_o = start_period_i;
      end
    end
  end

endmodule

@@ sv/stepper_ramp_step_generator_core.sv @@
// Stepper ramp step generator, one axis.
// The input channel carries one item per transaction: a load (mode 1) starts a move
// with a step count, a cruise period and a direction; a tick (mode 0) carries the two
// end-stop levels and advances the step timing by one tick.
// Every item produces exactly one result transaction with the pin levels, the position,
// the end-stop hits, the move status and the remaining step count.
// The configuration channel writes the start period (index 0) and the ramp step
// (index 1); its ready is always high. The user must make writes only while the block
// is idle; the block itself does not enforce this. An item is held in an input register
// and is then processed from there into the result register.
// Without a receiver stall the block sustains one item per clock; the step timing loop
// closes through the combinational period selection and its 20 by 16 bit multiplier.
// While the receiver stalls, the result register holds, the input register takes
// one more item and then input ready drops until the result is taken.
// Reset clears the move state, sets the position to 100000, restores the default
// start period of 2000 and ramp step of 10, and empties both registers.
`include "stepper_ramp_step_generator_core_defines.svh"

module stepper_ramp_step_generator_core import srsg_pkg::*; #(
  parameter int unsigned STEP_COUNT_BITS = StepCountBitsDef,
  parameter int unsigned PERIOD_BITS     = PeriodBitsDef,
  parameter int unsigned POSITION_BITS   = PositionBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [0:0]                 cfg_index_i,
  input  logic [CfgDataBits-1:0]     cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic                       left_stop_level_i,
  input  logic                       right_stop_level_i,
  input  logic [STEP_COUNT_BITS-1:0] move_length_i,
  input  logic [PERIOD_BITS-1:0]     target_period_i,
  input  logic                       direction_i,

  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       step_pin_o,
  output logic                       dir_pin_o,
  output logic [POSITION_BITS-1:0]   axis_position_o,
  output logic                       left_stop_hit_o,
  output logic                       right_stop_hit_o,
  output logic                       move_active_o,
  output logic                       step_taken_o,
  output logic [STEP_COUNT_BITS-1:0] steps_remaining_o
);

  logic [PERIOD_BITS-1:0] start_period_q;
  logic [RampBits-1:0]    ramp_step_q;

  logic                       in_valid_q;
  logic                       mode_q;
  logic                       left_stop_q;
  logic                       right_stop_q;
  logic [STEP_COUNT_BITS-1:0] move_length_q;
  logic [PERIOD_BITS-1:0]     target_period_q;
  logic                       direction_q;

  logic                       active_q, active_d;
  logic [STEP_COUNT_BITS-1:0] total_steps_q, total_steps_d;
  logic [STEP_COUNT_BITS-1:0] remaining_q, remaining_d;
  logic [PERIOD_BITS-1:0]     cruise_period_q, cruise_period_d;
  logic [PERIOD_BITS-1:0]     present_period_q, present_period_d;
  logic [PERIOD_BITS-1:0]     period_counter_q, period_counter_d;
  logic                       move_dir_q, move_dir_d;
  logic                       pulse_high_q, pulse_high_d;
  logic                       dir_level_q, dir_level_d;
  logic [POSITION_BITS-1:0]   position_q, position_d;

  logic                       out_valid_q;
  logic                       left_hit_q, left_hit_d;
  logic                       right_hit_q, right_hit_d;
  logic                       stepped_q, stepped_d;

  logic                       proc_fire;
  logic [PERIOD_BITS-1:0]     upcoming_period;

  assign cfg_ready_o = 1'b1;
  assign proc_fire   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_period_q <= PERIOD_BITS'(StartPeriodReset);
      ramp_step_q    <= RampStepReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgStartPeriod: start_period_q <= PERIOD_BITS'(cfg_data_i);
        CfgRampStep:    ramp_step_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q          <= mode_i;
      left_stop_q     <= left_stop_level_i;
      right_stop_q    <= right_stop_level_i;
      move_length_q   <= move_length_i;
      target_period_q <= target_period_i;
      direction_q     <= direction_i;
    end
  end

  srsg_period_pick #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS),
    .PERIOD_BITS    (PERIOD_BITS)
  ) u_period_pick (
    .total_steps_i    (total_steps_q),
    .remaining_steps_i(remaining_q),
    .present_period_i (present_period_q),
    .cruise_period_i  (cruise_period_q),
    .start_period_i   (start_period_q),
    .ramp_step_i      (ramp_step_q),
    .upcoming_period_o(upcoming_period)
  );

  always_comb begin
    active_d         = active_q;
    total_steps_d    = total_steps_q;
    remaining_d      = remaining_q;
    cruise_period_d  = cruise_period_q;
    present_period_d = present_period_q;
    period_counter_d = period_counter_q;
    move_dir_d       = move_dir_q;
    pulse_high_d     = pulse_high_q;
    dir_level_d      = dir_level_q;
    position_d       = position_q;
    left_hit_d       = 1'b0;
    right_hit_d      = 1'b0;
    stepped_d        = 1'b0;

    if (mode_q) begin
      total_steps_d    = move_length_q;
      remaining_d      = move_length_q;
      cruise_period_d  = target_period_q;
      move_dir_d       = direction_q;
      active_d         = 1'b1;
      present_period_d = start_period_q;
      period_counter_d = '0;
    end else begin
      left_hit_d  = left_stop_q;
      right_hit_d = right_stop_q;
      if ((left_stop_q && !move_dir_q) || (right_stop_q && move_dir_q)) begin
        active_d    = 1'b0;
        remaining_d = '0;
      end
      if (active_d && (remaining_d == '0)) begin
        active_d         = 1'b0;
        period_counter_d = '0;
      end
      if (!active_d) begin
        pulse_high_d = 1'b0;
      end else if (period_counter_q == '0) begin
        pulse_high_d     = 1'b1;
        stepped_d        = 1'b1;
        period_counter_d = upcoming_period;
        present_period_d = upcoming_period;
        remaining_d      = remaining_q - STEP_COUNT_BITS'(1);
        position_d       = move_dir_q ? position_q + POSITION_BITS'(1)
                                      : position_q - POSITION_BITS'(1);
      end else begin
        if (pulse_high_q) begin
          pulse_high_d = 1'b0;
          dir_level_d  = move_dir_q;
        end
        period_counter_d = period_counter_q - PERIOD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q         <= 1'b0;
      total_steps_q    <= '0;
      remaining_q      <= '0;
      cruise_period_q  <= '0;
      present_period_q <= '0;
      period_counter_q <= '0;
      move_dir_q       <= 1'b0;
      pulse_high_q     <= 1'b0;
      dir_level_q      <= 1'b0;
      position_q       <= POSITION_BITS'(HomePosition);
    end else if (proc_fire) begin
      active_q         <= active_d;
      total_steps_q    <= total_steps_d;
      remaining_q      <= remaining_d;
      cruise_period_q  <= cruise_period_d;
      present_period_q <= present_period_d;
      period_counter_q <= period_counter_d;
      move_dir_q       <= move_dir_d;
      pulse_high_q     <= pulse_high_d;
      dir_level_q      <= dir_level_d;
      position_q       <= position_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      left_hit_q  <= left_hit_d;
      right_hit_q <= right_hit_d;
      stepped_q   <= stepped_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign step_pin_o        = pulse_high_q;
  assign dir_pin_o         = dir_level_q;
  assign axis_position_o   = position_q;
  assign left_stop_hit_o   = left_hit_q;
  assign right_stop_hit_o  = right_hit_q;
  assign move_active_o     = active_q;
  assign step_taken_o      = stepped_q;
  assign steps_remaining_o = remaining_q;

  `SRSG_ASSERT(a_step_raises_pin, out_valid_o && step_taken_o |-> step_pin_o && move_active_o, "Step reported without a raised pin in an active move.")
  `SRSG_ASSERT_NEVER(a_pin_idle_low, step_pin_o && !move_active_o, "Step pin is high while no move is active.")
  `SRSG_ASSERT(a_idle_no_steps, !move_active_o |-> steps_remaining_o == '0, "Steps remain although no move is active.")
  `SRSG_ASSERT(a_stall_no_update, out_valid_o && !out_ready_i |=> $stable(position_q) && $stable(remaining_q), "Axis state changed while a result was stalled.")

endmodule
